[rtl/core/asa_pkg.sv]
// Shared types and constants for the aligned stack allocator.
package asa_pkg;

   localparam int HEADER_BYTES     = 16;
   localparam int MAX_LIVE         = 64;
   localparam int OFFSET_BITS      = 32;
   localparam int ALIGN_CLAMP_LOG2 = 7;
   localparam int ADDR_W           = 32;
   localparam int CSR_INDEX_W      = 2;

   localparam int ALIGN_MAX = 1 << ALIGN_CLAMP_LOG2;
   localparam int PAD_W     = $clog2(2 * ALIGN_MAX + HEADER_BYTES);
   localparam int IDX_W     = $clog2(MAX_LIVE);
   localparam int LIVE_W    = $clog2(MAX_LIVE + 1);
   localparam int SUM_W     = ((OFFSET_BITS > ADDR_W) ? OFFSET_BITS : ADDR_W) + 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_BUFFER_BASE = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_BUFFER_SIZE = CSR_INDEX_W'(1);

   typedef enum logic [1:0] {
      OP_ALLOC  = 2'd0,
      OP_FREE   = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_UNUSED = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_NO_SPACE  = 3'd1,
      ST_FULL      = 3'd2,
      ST_IGNORED   = 3'd3,
      ST_RANGE     = 3'd4,
      ST_NOT_FOUND = 3'd5
   } status_type;

   typedef struct packed {
      op_type      op;
      logic [31:0] data_size;
      logic [3:0]  align_log2;
      logic [31:0] free_address;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] block_address;
      logic [31:0] used_bytes;
   } rsp_type;

   typedef struct packed {
      logic [OFFSET_BITS-1:0] start;
      logic [OFFSET_BITS-1:0] data;
   } record_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ALLOC_PAD,
      S_ALLOC_FIT,
      S_FREE_CHECK,
      S_FREE_SCAN,
      S_CLEAR,
      S_IGNORE
   } state_type;

   typedef struct packed {
      logic       load;
      logic       alloc_commit;
      logic       free_start;
      logic       scan_next;
      logic       pop;
      logic       clear;
      logic       respond;
      status_type rsp_status;
   } ctrl_cmd_type;

   typedef struct packed {
      logic alloc_fits;
      logic live_full;
      logic live_empty;
      logic free_null;
      logic free_range;
      logic free_above;
      logic scan_hit;
      logic scan_last;
   } dp_status_type;

endpackage

[rtl/core/asa_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module asa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/asa_dp.sv]
// Datapath: config registers, stack top, record memory, padding and result registers.
module asa_dp (
   input  logic                           clock,
   input  logic                           reset,
   input  asa_pkg::req_type               req_item,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [asa_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]                    csr_wdata,
   input  asa_pkg::ctrl_cmd_type          cmd,
   output asa_pkg::dp_status_type         sts,
   output logic                           rsp_valid,
   output asa_pkg::rsp_type               rsp_item
);
   import asa_pkg::*;

   logic [ADDR_W-1:0]      base_ff, base_in;
   logic [ADDR_W-1:0]      size_ff, size_in;
   logic [OFFSET_BITS-1:0] top_ff, top_in;
   logic [LIVE_W-1:0]      live_ff, live_in;
   logic [IDX_W-1:0]       ptr_ff, ptr_in;
   logic [PAD_W-1:0]       pad_ff, pad_in;
   req_type                req_ff, req_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic [ADDR_W-1:0]      cur;
   logic [2:0]             lg;
   logic [PAD_W-1:0]       a_mask;
   logic [PAD_W-1:0]       rem;
   logic [PAD_W-1:0]       pad0;
   logic [PAD_W-1:0]       need;
   logic [SUM_W-1:0]       fit_sum;
   logic [OFFSET_BITS-1:0] data_off;
   logic [ADDR_W-1:0]      blk_addr;
   logic [ADDR_W-1:0]      off;
   logic                   rd_en;
   logic [IDX_W-1:0]       rd_addr;
   record_type             wr_rec;
   logic [$bits(record_type)-1:0] rd_raw;
   record_type             rd_rec;

   assign csr_ready = 1'b1;

   always_comb begin
      base_in = base_ff;
      size_in = size_ff;
      if (csr_valid && csr_index == CSR_BUFFER_BASE) begin
         base_in = csr_wdata;
      end
      if (csr_valid && csr_index == CSR_BUFFER_SIZE) begin
         size_in = csr_wdata;
      end
   end

   assign req_in = cmd.load ? req_item : req_ff;

   // Padding: align the block address and leave header room in front of it.
   assign cur    = base_ff + ADDR_W'(top_ff);
   assign lg     = (req_ff.align_log2 > 4'(ALIGN_CLAMP_LOG2)) ? 3'(ALIGN_CLAMP_LOG2)
                                                             : req_ff.align_log2[2:0];
   assign a_mask = (PAD_W'(1) << lg) - PAD_W'(1);
   assign rem    = PAD_W'(cur[ALIGN_CLAMP_LOG2-1:0]) & a_mask;
   assign pad0   = (rem != '0) ? (a_mask + PAD_W'(1) - rem) : '0;
   assign need   = PAD_W'(HEADER_BYTES) - pad0;
   assign pad_in = (pad0 < PAD_W'(HEADER_BYTES)) ? (pad0 + ((need + a_mask) & ~a_mask))
                                                 : pad0;

   // Fit check against the buffer size and the offset range.
   assign fit_sum  = SUM_W'(top_ff) + SUM_W'(pad_ff) + SUM_W'(req_ff.data_size);
   assign data_off = top_ff + OFFSET_BITS'(pad_ff);
   assign blk_addr = base_ff + ADDR_W'(data_off);
   assign off      = req_ff.free_address - base_ff;

   assign rd_rec = record_type'(rd_raw);

   always_comb begin
      sts.alloc_fits = (fit_sum <= SUM_W'(size_ff)) &&
                       (fit_sum[SUM_W-1:OFFSET_BITS] == '0);
      sts.live_full  = live_ff >= LIVE_W'(MAX_LIVE);
      sts.live_empty = live_ff == '0;
      sts.free_null  = req_ff.free_address == '0;
      sts.free_range = off >= size_ff;
      sts.free_above = SUM_W'(off) >= SUM_W'(top_ff);
      sts.scan_hit   = SUM_W'(rd_rec.data) == SUM_W'(off);
      sts.scan_last  = ptr_ff == '0;
   end

   // Record memory: push on allocate, walk down from the top on a free.
   assign wr_rec.start = top_ff;
   assign wr_rec.data  = data_off;
   assign rd_en        = cmd.free_start || cmd.scan_next;
   assign rd_addr      = cmd.free_start ? IDX_W'(live_ff - LIVE_W'(1)) : (ptr_ff - IDX_W'(1));
   assign ptr_in       = rd_en ? rd_addr : ptr_ff;

   asa_ram #(
      .WIDTH ($bits(record_type)),
      .DEPTH (MAX_LIVE)
   ) u_rec_ram (
      .clock   (clock),
      .wr_en   (cmd.alloc_commit),
      .wr_addr (live_ff[IDX_W-1:0]),
      .wr_data (wr_rec),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   always_comb begin
      top_in  = top_ff;
      live_in = live_ff;
      if (cmd.clear) begin
         top_in  = '0;
         live_in = '0;
      end else if (cmd.alloc_commit) begin
         top_in  = fit_sum[OFFSET_BITS-1:0];
         live_in = live_ff + LIVE_W'(1);
      end else if (cmd.pop) begin
         top_in  = rd_rec.start;
         live_in = LIVE_W'(ptr_ff);
      end
   end

   always_comb begin
      rsp_valid_in         = cmd.respond;
      rsp_in.status        = cmd.rsp_status;
      rsp_in.block_address = cmd.alloc_commit ? blk_addr : '0;
      rsp_in.used_bytes    = 32'(top_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= '0;
         size_ff      <= '0;
         top_ff       <= '0;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         base_ff      <= base_in;
         size_ff      <= size_in;
         top_ff       <= top_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      pad_ff <= pad_in;
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

`ifndef SYNTHESIS
   a_live_bound: assert property (@(posedge clock) disable iff (reset)
      live_ff <= LIVE_W'(MAX_LIVE))
      else $error("record count above capacity");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe held two cycles");

   a_fail_addr_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status != ST_OK) |-> (rsp_ff.block_address == '0))
      else $error("failed step returned an address");
`endif

endmodule

[rtl/core/asa_ctrl.sv]
// Controller state machine: sequences allocate, free search and clear.
module asa_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  asa_pkg::op_type        op,
   input  asa_pkg::dp_status_type sts,
   output asa_pkg::ctrl_cmd_type  cmd,
   output logic                   busy
);
   import asa_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (op)
                  OP_ALLOC: state_in = S_ALLOC_PAD;
                  OP_FREE:  state_in = S_FREE_CHECK;
                  OP_CLEAR: state_in = S_CLEAR;
                  default:  state_in = S_IGNORE;
               endcase
            end
         end
         S_ALLOC_PAD: state_in = S_ALLOC_FIT;
         S_ALLOC_FIT: state_in = S_IDLE;
         S_FREE_CHECK: begin
            if (sts.free_null || sts.free_range || sts.free_above || sts.live_empty) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_FREE_SCAN;
            end
         end
         S_FREE_SCAN: begin
            if (sts.scan_hit || sts.scan_last) begin
               state_in = S_IDLE;
            end
         end
         S_CLEAR:  state_in = S_IDLE;
         S_IGNORE: state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '0;
      cmd.rsp_status = ST_IGNORED;
      busy = state_ff != S_IDLE;
      case (state_ff)
         S_IDLE: begin
            cmd.load = start;
         end
         S_ALLOC_PAD: begin
         end
         S_ALLOC_FIT: begin
            cmd.respond = 1'b1;
            if (!sts.alloc_fits) begin
               cmd.rsp_status = ST_NO_SPACE;
            end else if (sts.live_full) begin
               cmd.rsp_status = ST_FULL;
            end else begin
               cmd.rsp_status   = ST_OK;
               cmd.alloc_commit = 1'b1;
            end
         end
         S_FREE_CHECK: begin
            if (sts.free_null) begin
               cmd.respond    = 1'b1;
               cmd.rsp_status = ST_IGNORED;
            end else if (sts.free_range) begin
               cmd.respond    = 1'b1;
               cmd.rsp_status = ST_RANGE;
            end else if (sts.free_above) begin
               cmd.respond    = 1'b1;
               cmd.rsp_status = ST_IGNORED;
            end else if (sts.live_empty) begin
               cmd.respond    = 1'b1;
               cmd.rsp_status = ST_NOT_FOUND;
            end else begin
               cmd.free_start = 1'b1;
            end
         end
         S_FREE_SCAN: begin
            // Compare the entry read last cycle, fetch the one below on a miss.
            if (sts.scan_hit) begin
               cmd.pop        = 1'b1;
               cmd.respond    = 1'b1;
               cmd.rsp_status = ST_OK;
            end else if (sts.scan_last) begin
               cmd.respond    = 1'b1;
               cmd.rsp_status = ST_NOT_FOUND;
            end else begin
               cmd.scan_next = 1'b1;
            end
         end
         S_CLEAR: begin
            cmd.clear      = 1'b1;
            cmd.respond    = 1'b1;
            cmd.rsp_status = ST_OK;
         end
         S_IGNORE: begin
            cmd.respond    = 1'b1;
            cmd.rsp_status = ST_IGNORED;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted beat did not raise busy");

   a_respond_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.respond |=> (state_ff == S_IDLE))
      else $error("controller kept working after responding");

   a_commit_room: assert property (@(posedge clock) disable iff (reset)
      cmd.alloc_commit |-> !sts.live_full)
      else $error("record pushed onto a full stack");
`endif

endmodule

[rtl/core/aligned_stack_allocator.sv]
// Aligned stack allocator: bounded record stack over a configured byte buffer.
//
// Usage:
//   Command channel: drive req_item and raise start; the beat is taken at an edge
//   where start is high and busy is low. One result per command.
//   Result channel: rsp_valid is high for exactly one cycle with rsp_item; the
//   receiver cannot stall it, so capture it in that cycle.
//   Config channel: csr_valid with csr_index/csr_wdata, always ready. Index 0 is
//   buffer_base, index 1 is buffer_size; other indexes are dropped. Write only
//   while busy is low and no result is pending.
//   Steps from the accepting edge: clear, unused op and a free rejected by its
//   checks respond from one state; allocate passes S_ALLOC_PAD, S_ALLOC_FIT; a
//   searching free passes S_FREE_CHECK, then S_FREE_SCAN, which reads the record
//   RAM one entry per cycle from the top down, up to the live count (at most 64).
//   A new command may be accepted in the result cycle.
//   Reset: synchronous, active high; clears the stack, both config registers and
//   the controller. The record RAM needs no clearing pass.
module aligned_stack_allocator (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  asa_pkg::req_type                req_item,
   output logic                            rsp_valid,
   output asa_pkg::rsp_type                rsp_item,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [asa_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]                     csr_wdata
);
   import asa_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type sts;

   asa_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .op    (req_item.op),
      .sts   (sts),
      .cmd   (cmd),
      .busy  (busy)
   );

   asa_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

[bench/asa_checker.sv]
// Result checker for the aligned stack allocator: tracks its state and compares every result.
module asa_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            busy,
   input  asa_pkg::req_type                req_item,
   input  logic                            rsp_valid,
   input  asa_pkg::rsp_type                rsp_item,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [asa_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]                     csr_wdata,
   output int                              mismatches,
   output int                              outstanding
);
   timeunit 1ns;
   timeprecision 1ps;
   import asa_pkg::*;

   localparam longint unsigned OFFSET_LIMIT = (64'd1 << OFFSET_BITS) - 1;

   logic [31:0]            base_reg;
   logic [31:0]            size_reg;
   logic [OFFSET_BITS-1:0] top_off;
   int                     live;
   logic [OFFSET_BITS-1:0] rec_start [MAX_LIVE];
   logic [OFFSET_BITS-1:0] rec_data [MAX_LIVE];
   rsp_type                awaited_rsp [$];

   // Distance up to the next aligned address, widened until the header fits in front.
   function automatic longint unsigned header_pad(logic [31:0] addr, int unsigned lg);
      longint unsigned a;
      longint unsigned rem;
      longint unsigned pad;
      a = 64'd1 << lg;
      rem = addr & (a - 1);
      pad = (rem != 0) ? a - rem : 0;
      if (pad < HEADER_BYTES)
         pad += a * ((HEADER_BYTES - pad + a - 1) / a);
      return pad;
   endfunction

   function automatic rsp_type allocator_step(req_type r);
      rsp_type         res;
      int unsigned     lg;
      longint unsigned pad;
      longint unsigned cap;
      longint unsigned data_off;
      logic [31:0]     off;
      bit              found;
      res.status = ST_IGNORED;
      res.block_address = '0;
      case (r.op)
         OP_ALLOC: begin
            lg = (r.align_log2 > ALIGN_CLAMP_LOG2) ? ALIGN_CLAMP_LOG2 : r.align_log2;
            pad = header_pad(base_reg + top_off, lg);
            cap = (size_reg > OFFSET_LIMIT) ? OFFSET_LIMIT : size_reg;
            if (top_off > cap || pad > cap - top_off || r.data_size > cap - top_off - pad) begin
               res.status = ST_NO_SPACE;
            end else if (live >= MAX_LIVE) begin
               res.status = ST_FULL;
            end else begin
               data_off = top_off + pad;
               rec_start[live] = top_off;
               rec_data[live] = data_off[OFFSET_BITS-1:0];
               live++;
               top_off = OFFSET_BITS'(data_off + r.data_size);
               res.block_address = base_reg + data_off[31:0];
               res.status = ST_OK;
            end
         end
         OP_FREE: begin
            off = r.free_address - base_reg;
            if (r.free_address == 0) begin
               res.status = ST_IGNORED;
            end else if (off >= size_reg) begin
               res.status = ST_RANGE;
            end else if (off >= top_off) begin
               res.status = ST_IGNORED;
            end else begin
               // search from the newest block down; a hit drops everything above it
               res.status = ST_NOT_FOUND;
               found = 0;
               for (int i = live - 1; i >= 0 && !found; i--) begin
                  if (rec_data[i] == off) begin
                     top_off = rec_start[i];
                     live = i;
                     found = 1;
                     res.status = ST_OK;
                  end
               end
            end
         end
         OP_CLEAR: begin
            top_off = '0;
            live = 0;
            res.status = ST_OK;
         end
         default: res.status = ST_IGNORED;
      endcase
      res.used_bytes = top_off;
      return res;
   endfunction

   function automatic bit field_differs(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
         return 1;
      end
      return 0;
   endfunction

   initial mismatches = 0;

   always @(posedge clock) begin : watch
      rsp_type want;
      bit      bad;
      if (reset) begin
         base_reg = '0;
         size_reg = '0;
         top_off = '0;
         live = 0;
         awaited_rsp.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_BUFFER_BASE: base_reg = csr_wdata;
               CSR_BUFFER_SIZE: size_reg = csr_wdata;
               default: ;
            endcase
         end
         // check the result beat before taking a new command in the same cycle
         if (rsp_valid) begin
            if (awaited_rsp.size() == 0) begin
               $display("%0t ns: unexpected result, expected none, actual %p",
                        $time, rsp_item);
               mismatches++;
            end else begin
               want = awaited_rsp.pop_front();
               bad = field_differs("status", 32'(want.status), 32'(rsp_item.status))
                   | field_differs("block_address", want.block_address,
                                   rsp_item.block_address)
                   | field_differs("used_bytes", want.used_bytes, rsp_item.used_bytes);
               if (bad)
                  mismatches++;
            end
         end
         if (start && !busy)
            awaited_rsp.push_back(allocator_step(req_item));
      end
      outstanding <= awaited_rsp.size();
   end

endmodule

[bench/testbench.sv]
// Top of the allocator bench: clock, reset, command and register stimulus, and the verdict.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import asa_pkg::*;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   req_type                req_item;
   logic                   rsp_valid;
   rsp_type                rsp_item;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [31:0]            csr_wdata;
   int                     mismatches;
   int                     outstanding;

   int          item_count;
   int          gap_max;
   logic [31:0] cur_base;
   logic [31:0] cur_size;
   logic [31:0] handed_out [$];
   logic [31:0] phase_base [6];
   logic [31:0] phase_size [6];

   aligned_stack_allocator DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   asa_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_item    (rsp_item),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5000000;
      $display("status: fail");
      $finish;
   end

   // collect granted addresses so later frees hit live blocks
   always @(negedge clock) begin
      if (!reset && rsp_valid && rsp_item.status == ST_OK && rsp_item.block_address != 0) begin
         handed_out.push_back(rsp_item.block_address);
         if (handed_out.size() > 96)
            void'(handed_out.pop_front());
      end
   end

   function automatic req_type alloc_req(logic [31:0] size, logic [3:0] align);
      req_type r;
      r.op = OP_ALLOC;
      r.data_size = size;
      r.align_log2 = align;
      r.free_address = $urandom;
      return r;
   endfunction

   function automatic req_type free_req(logic [31:0] addr);
      req_type r;
      r.op = OP_FREE;
      r.data_size = $urandom;
      r.align_log2 = 4'($urandom);
      r.free_address = addr;
      return r;
   endfunction

   function automatic req_type ctl_req(op_type op);
      req_type r;
      r.op = op;
      r.data_size = $urandom;
      r.align_log2 = 4'($urandom);
      r.free_address = $urandom;
      return r;
   endfunction

   function automatic logic [31:0] noise_addr();
      case ($urandom_range(0, 3))
         0: return 32'h0;
         1: return $urandom;
         2: return cur_base + $urandom_range(1, 300);
         default: return cur_base + cur_size + $urandom_range(0, 16);
      endcase
   endfunction

   // hold the beat until an edge sees busy low, then idle for a random gap
   task automatic issue(req_type r);
      bit idle_seen;
      int gap;
      req_item <= r;
      start <= 1'b1;
      do begin
         @(negedge clock);
         idle_seen = !busy;
         @(posedge clock);
      end while (!idle_seen);
      item_count++;
      gap = $urandom_range(0, gap_max);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [31:0] value);
      bit ready_seen;
      csr_index <= idx;
      csr_wdata <= value;
      csr_valid <= 1'b1;
      do begin
         @(negedge clock);
         ready_seen = csr_ready;
         @(posedge clock);
      end while (!ready_seen);
   endtask

   // drain every pending result, then reprogram the buffer window
   task automatic set_buffer(logic [31:0] base, logic [31:0] size);
      start <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      @(posedge clock);
      write_reg(CSR_BUFFER_BASE, base);
      write_reg(CSR_BUFFER_SIZE, size);
      csr_valid <= 1'b0;
      cur_base = base;
      cur_size = size;
      handed_out.delete();
   endtask

   initial begin
      int pick;
      int idx;
      int target;
      reset <= 1'b1;
      start <= 1'b0;
      req_item <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      item_count = 0;
      gap_max = 3;
      cur_base = '0;
      cur_size = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // empty window after reset: nothing fits, every free is out of range
      issue(alloc_req(32'h0, 4'h0));
      issue(free_req(32'h10));
      issue(ctl_req(OP_CLEAR));

      set_buffer(32'h0000_1000, 32'd4096);
      issue(alloc_req(32'd0, 4'd0));
      issue(alloc_req(32'd100, 4'd15));
      issue(alloc_req(32'd32, 4'd7));
      issue(alloc_req(32'hFFFF_FFFF, 4'd3));
      issue(free_req(32'h0));
      issue(free_req(32'h0000_2000));
      issue(free_req(32'h0000_1000 + 32'd4000));
      issue(free_req(32'h0000_1001));
      issue(free_req(32'h0000_1080));   // out of order: drops the block above too
      issue(free_req(32'h0000_1010));
      issue(ctl_req(OP_UNUSED));

      // base near the top of the address space: first block lands at address 0
      set_buffer(32'hFFFF_FFF0, 32'd64);
      issue(alloc_req(32'd0, 4'd0));
      issue(alloc_req(32'd48, 4'd4));
      issue(alloc_req(32'd32, 4'd4));
      issue(free_req(32'h0000_0010));
      issue(free_req(32'h0000_0030));
      issue(ctl_req(OP_CLEAR));

      set_buffer(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      issue(alloc_req(32'hFFFF_FFEF, 4'd0));
      issue(alloc_req(32'd0, 4'd0));
      issue(free_req(32'h0000_000F));
      issue(ctl_req(OP_CLEAR));

      phase_base[0] = 32'h0000_1000;  phase_size[0] = 32'd4096;
      phase_base[1] = $urandom;       phase_size[1] = 32'hFFFF_FFFF;
      phase_base[2] = 32'hFFFF_FFF0;  phase_size[2] = 32'd2048;
      phase_base[3] = $urandom;       phase_size[3] = $urandom_range(0, 300);
      phase_base[4] = 32'h0;          phase_size[4] = 32'hFFFF_FFFF;
      phase_base[5] = 32'h8000_0001;  phase_size[5] = 32'd65536;

      for (int ph = 0; ph < 6; ph++) begin
         set_buffer(phase_base[ph], phase_size[ph]);
         target = item_count + 110;
         while (item_count < target) begin
            gap_max = ($urandom_range(0, 3) == 0) ? 0 : 19;
            pick = $urandom_range(0, 9);
            if (pick < 2) begin
               // push past the record limit with tiny blocks
               repeat (MAX_LIVE + 2)
                  issue(alloc_req($urandom_range(0, 8), 4'($urandom_range(0, 15))));
            end else if (pick < 9) begin
               repeat (20) begin
                  pick = $urandom_range(0, 99);
                  if (pick < 45) begin
                     issue(alloc_req(($urandom_range(0, 9) == 0) ? $urandom
                                                                : $urandom_range(0, 200),
                                     4'($urandom_range(0, 15))));
                  end else if (pick < 80 && handed_out.size() != 0) begin
                     // mostly the newest block; sometimes an older one
                     idx = ($urandom_range(0, 3) != 0) ? handed_out.size() - 1
                                                     : $urandom_range(0, handed_out.size() - 1);
                     issue(free_req(handed_out[idx]));
                     handed_out.delete(idx);
                  end else if (pick < 94) begin
                     issue(free_req(noise_addr()));
                  end else if (pick < 97) begin
                     issue(ctl_req(OP_CLEAR));
                     handed_out.delete();
                  end else begin
                     issue(ctl_req(OP_UNUSED));
                  end
               end
            end else begin
               issue(ctl_req(OP_CLEAR));
               handed_out.delete();
            end
         end
      end

      start <= 1'b0;
      for (int w = 0; w < 2000 && outstanding != 0; w++)
         @(negedge clock);
      repeat (80) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
